### hdl/phts_pkg.sv
// Shared constants, types and the opcode decoder for the hazard timing scoreboard.
// No dependencies; every other file in hdl/ except phts_ram refers to it by scoped names.
package phts_pkg;

	localparam int NUM_REGS_DEF   = 32;
	localparam int MAX_SPAN_DEF   = 16;
	localparam int CYCLE_BITS_DEF = 32;
	localparam int WORD_BITS      = 32;
	localparam int OUT_BITS       = 32;
	localparam int CLASS_BITS     = 3;

	localparam logic [6:0] OP_R      = 7'b0110011;
	localparam logic [6:0] OP_I      = 7'b0010011;
	localparam logic [6:0] OP_LOAD   = 7'b0000011;
	localparam logic [6:0] OP_STORE  = 7'b0100011;
	localparam logic [6:0] OP_BRANCH = 7'b1100011;

	typedef enum logic [CLASS_BITS-1:0] {
		CLS_R       = 3'd0,
		CLS_I       = 3'd1,
		CLS_LOAD    = 3'd2,
		CLS_STORE   = 3'd3,
		CLS_BRANCH  = 3'd4,
		CLS_UNKNOWN = 3'd5
	} cls_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PRE,
		S_FINC,
		S_SKIP,
		S_STEP,
		S_RD1,
		S_RD2,
		S_RSEL,
		S_WCMP,
		S_WJMP,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		PH_ID,
		PH_EX,
		PH_MEM,
		PH_WB
	} phase_t;

	// status of the shared step unit
	typedef struct packed {
		logic a_max;
		logic ge;
	} unit_flags_t;

	function automatic cls_t decode_class(input logic [6:0] op);
		cls_t c;
		case (op)
			OP_R:      c = CLS_R;
			OP_I:      c = CLS_I;
			OP_LOAD:   c = CLS_LOAD;
			OP_STORE:  c = CLS_STORE;
			OP_BRANCH: c = CLS_BRANCH;
			default:   c = CLS_UNKNOWN;
		endcase
		return c;
	endfunction

endpackage

### hdl/phts_if.sv
// Valid/ready channel interfaces: instruction requests in, stage timing results out.
// Depends on phts_pkg for field widths.
interface phts_in_if;
	logic                             valid;
	logic                             ready;
	logic [phts_pkg::WORD_BITS-1:0]   instruction_word;

	modport source (output valid, output instruction_word, input ready);
	modport sink (input valid, input instruction_word, output ready);
endinterface

interface phts_out_if;
	logic                             valid;
	logic                             ready;
	logic [phts_pkg::CLASS_BITS-1:0]  instr_class;
	logic [phts_pkg::OUT_BITS-1:0]    fetch_cycle;
	logic [phts_pkg::OUT_BITS-1:0]    decode_cycle;
	logic [phts_pkg::OUT_BITS-1:0]    execute_cycle;
	logic [phts_pkg::OUT_BITS-1:0]    memory_cycle;
	logic [phts_pkg::OUT_BITS-1:0]    writeback_cycle;
	logic                             span_overflow;

	modport source (output valid, output instr_class, output fetch_cycle, output decode_cycle,
		output execute_cycle, output memory_cycle, output writeback_cycle,
		output span_overflow, input ready);
	modport sink (input valid, input instr_class, input fetch_cycle, input decode_cycle,
		input execute_cycle, input memory_cycle, input writeback_cycle,
		input span_overflow, output ready);
endinterface

### hdl/phts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module phts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/phts_step_unit.sv
// Shared cycle arithmetic: saturating increment, compare and clamped span offset.
// Depends on phts_pkg for the flag struct.
module phts_step_unit #(
	parameter int CYCLE_BITS = 32,
	parameter int MAX_SPAN   = 16
) (
	input  logic [CYCLE_BITS-1:0]           a,
	input  logic [CYCLE_BITS-1:0]           b,
	output logic [CYCLE_BITS-1:0]           inc,
	output logic [$clog2(MAX_SPAN+1)-1:0]   off,
	output phts_pkg::unit_flags_t           flags
);

	localparam int SPW = $clog2(MAX_SPAN + 1);

	logic [CYCLE_BITS-1:0] diff;

	always_comb begin
		flags.a_max = &a;
		flags.ge    = (a >= b);
		inc         = flags.a_max ? a : a + CYCLE_BITS'(1);
		diff        = a - b;
		// offsets past the span window all read as MAX_SPAN
		off         = (diff > CYCLE_BITS'(MAX_SPAN)) ? SPW'(MAX_SPAN) : diff[SPW-1:0];
	end

endmodule

### hdl/pipeline_hazard_timing_scoreboard.sv
// From the accepting edge, the time to a valid result depends on the instruction class; a
// source wait that jumps ahead lengthens it, and so does each stall cell of the previous row
// that is waited out. One request is in work at a time, and a result held by the sink stalls
// the last step.
// Reset (arst_n low): ready table reads as all zero, last fetch and stall mask clear, idle.
module pipeline_hazard_timing_scoreboard #(
	parameter int NUM_REGS   = phts_pkg::NUM_REGS_DEF,
	parameter int MAX_SPAN   = phts_pkg::MAX_SPAN_DEF,
	parameter int CYCLE_BITS = phts_pkg::CYCLE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	phts_in_if.sink      instr,
	phts_out_if.source   timing
);

	localparam int RIW = $clog2(NUM_REGS);
	localparam int SPW = $clog2(MAX_SPAN + 1);
	localparam int SIW = $clog2(MAX_SPAN);
	localparam logic [CYCLE_BITS-1:0] CYC_MAX    = {CYCLE_BITS{1'b1}};
	localparam logic [CYCLE_BITS-1:0] CYC_MAX_M1 = {{(CYCLE_BITS-1){1'b1}}, 1'b0};
	localparam logic [SPW-1:0]        SPAN_OFF   = SPW'(MAX_SPAN);

	// Offsets are kept narrow and clamped at MAX_SPAN:
	//   offl = min(cur - last_fetch - 1, MAX_SPAN)  indexes the previous row's stall mask
	//   offf = min(cur - fetch - 1, MAX_SPAN)       indexes this row's own stall mask
	// Both step with cur; a jump on a register wait recomputes offf through the step
	// unit and rebuilds offl from dfl = min(fetch - last_fetch, MAX_SPAN).

	// control state
	phts_pkg::state_t  st_q, st_d;
	phts_pkg::phase_t  ph_q, ph_d;
	logic              out_valid_q, out_valid_d;
	logic [NUM_REGS-1:0] vld_q, vld_d;
	logic [CYCLE_BITS-1:0] lf_q, lf_d;
	logic [MAX_SPAN-1:0]   pm_q, pm_d;

	// per-request working registers
	phts_pkg::cls_t        cls_q, cls_d;
	logic [RIW-1:0]        rd_q, rd_d, rs1_q, rs1_d, rs2_q, rs2_d;
	logic [CYCLE_BITS-1:0] cur_q, cur_d, f_q, f_d, d_q, d_d, e_q, e_d, m_q, m_d;
	logic [CYCLE_BITS-1:0] rdy_q, rdy_d;
	logic [SPW-1:0]        offl_q, offl_d, offf_q, offf_d, dfl_q, dfl_d;
	logic [MAX_SPAN-1:0]   own_q, own_d;
	logic                  fmax_q, fmax_d;
	logic                  rvld_q, rvld_d;

	// result register
	logic [phts_pkg::CLASS_BITS-1:0] o_cls_q, o_cls_d;
	logic [phts_pkg::OUT_BITS-1:0]   o_f_q, o_f_d, o_d_q, o_d_d, o_e_q, o_e_d;
	logic [phts_pkg::OUT_BITS-1:0]   o_m_q, o_m_d, o_wb_q, o_wb_d;
	logic                            o_ovf_q, o_ovf_d;

	// shared unit and ready table
	logic [CYCLE_BITS-1:0]  u_a, u_b, u_inc;
	logic [SPW-1:0]         u_off;
	phts_pkg::unit_flags_t  u_flg;
	logic                   ram_we, ram_re;
	logic [RIW-1:0]         ram_waddr, ram_raddr;
	logic [CYCLE_BITS-1:0]  ram_rdata, rd_data;

	logic cur_max, adv;

	function automatic logic [phts_pkg::OUT_BITS-1:0] low_word(input logic [CYCLE_BITS-1:0] c);
		logic [CYCLE_BITS+phts_pkg::OUT_BITS-1:0] x;
		x = {{phts_pkg::OUT_BITS{1'b0}}, c};
		return x[phts_pkg::OUT_BITS-1:0];
	endfunction

	function automatic logic [SPW-1:0] off_inc(input logic [SPW-1:0] x);
		return (x >= SPAN_OFF) ? SPAN_OFF : x + SPW'(1);
	endfunction

	phts_step_unit #(
		.CYCLE_BITS (CYCLE_BITS),
		.MAX_SPAN   (MAX_SPAN)
	) u_step (
		.a     (u_a),
		.b     (u_b),
		.inc   (u_inc),
		.off   (u_off),
		.flags (u_flg)
	);

	phts_ram #(
		.WIDTH (CYCLE_BITS),
		.DEPTH (NUM_REGS)
	) u_ready_tbl (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cur_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// never-written entries read as zero
	assign rd_data = rvld_q ? ram_rdata : '0;
	assign cur_max = &cur_q;
	// one cell of the previous row's stall mask is waited out
	assign adv     = !cur_max && (offl_q < SPAN_OFF) && pm_q[offl_q[SIW-1:0]];

	assign instr.ready           = (st_q == phts_pkg::S_IDLE);
	assign timing.valid          = out_valid_q;
	assign timing.instr_class    = o_cls_q;
	assign timing.fetch_cycle    = o_f_q;
	assign timing.decode_cycle   = o_d_q;
	assign timing.execute_cycle  = o_e_q;
	assign timing.memory_cycle   = o_m_q;
	assign timing.writeback_cycle = o_wb_q;
	assign timing.span_overflow  = o_ovf_q;

	// unit operand select
	always_comb begin
		u_a = cur_q;
		u_b = f_q;
		case (st_q)
			phts_pkg::S_IDLE: u_a = lf_q;
			phts_pkg::S_RSEL: begin
				u_a = rdy_q;
				u_b = rd_data;
			end
			phts_pkg::S_WCMP: begin
				u_a = rdy_q;
				u_b = cur_q;
			end
			// n - f - 1 with n = sat_inc(ready)
			phts_pkg::S_WJMP: u_a = (&rdy_q) ? CYC_MAX_M1 : rdy_q;
			default: ;
		endcase
	end

	// sequencer: next state and datapath
	always_comb begin
		logic [SPW:0] sum;
		sum = '0;

		st_d        = st_q;
		ph_d        = ph_q;
		out_valid_d = (out_valid_q && timing.ready) ? 1'b0 : out_valid_q;
		vld_d       = vld_q;
		lf_d        = lf_q;
		pm_d        = pm_q;
		cls_d       = cls_q;
		rd_d        = rd_q;
		rs1_d       = rs1_q;
		rs2_d       = rs2_q;
		cur_d       = cur_q;
		f_d         = f_q;
		d_d         = d_q;
		e_d         = e_q;
		m_d         = m_q;
		rdy_d       = rdy_q;
		offl_d      = offl_q;
		offf_d      = offf_q;
		dfl_d       = dfl_q;
		own_d       = own_q;
		fmax_d      = fmax_q;
		rvld_d      = rvld_q;
		o_cls_d     = o_cls_q;
		o_f_d       = o_f_q;
		o_d_d       = o_d_q;
		o_e_d       = o_e_q;
		o_m_d       = o_m_q;
		o_wb_d      = o_wb_q;
		o_ovf_d     = o_ovf_q;
		ram_we      = 1'b0;
		ram_waddr   = rd_q;
		ram_re      = 1'b0;
		ram_raddr   = rs1_q;

		case (st_q)
			phts_pkg::S_IDLE: begin
				if (instr.valid) begin
					cls_d  = phts_pkg::decode_class(instr.instruction_word[6:0]);
					rd_d   = instr.instruction_word[7 +: RIW];
					rs1_d  = instr.instruction_word[15 +: RIW];
					rs2_d  = instr.instruction_word[20 +: RIW];
					cur_d  = u_inc;
					offl_d = '0;
					e_d    = '0;
					m_d    = '0;
					own_d  = '0;
					st_d   = phts_pkg::S_PRE;
				end
			end
			// stalls before IF belong to the previous row only
			phts_pkg::S_PRE: begin
				if (adv) begin
					cur_d  = u_inc;
					offl_d = off_inc(offl_q);
				end else begin
					f_d    = cur_q;
					fmax_d = cur_max;
					st_d   = phts_pkg::S_FINC;
				end
			end
			phts_pkg::S_FINC: begin
				cur_d  = u_inc;
				offf_d = '0;
				if (!cur_max) begin
					offl_d = off_inc(offl_q);
					dfl_d  = off_inc(offl_q);
				end
				ph_d = phts_pkg::PH_ID;
				st_d = phts_pkg::S_SKIP;
			end
			// wait out the previous row's stall cells, marking them as our own
			phts_pkg::S_SKIP: begin
				if (adv) begin
					cur_d  = u_inc;
					offl_d = off_inc(offl_q);
					offf_d = off_inc(offf_q);
					if (offf_q < SPAN_OFF) begin
						own_d[offf_q[SIW-1:0]] = 1'b1;
					end
				end else begin
					case (ph_q)
						phts_pkg::PH_ID: begin
							d_d  = cur_q;
							ph_d = (cls_q <= phts_pkg::CLS_STORE) ? phts_pkg::PH_EX
								: phts_pkg::PH_WB;
							st_d = phts_pkg::S_STEP;
						end
						phts_pkg::PH_EX: begin
							e_d  = cur_q;
							ph_d = phts_pkg::PH_MEM;
							st_d = phts_pkg::S_STEP;
						end
						phts_pkg::PH_MEM: begin
							m_d  = cur_q;
							ph_d = phts_pkg::PH_WB;
							st_d = phts_pkg::S_STEP;
						end
						phts_pkg::PH_WB: st_d = phts_pkg::S_DONE;
						default: st_d = phts_pkg::S_DONE;
					endcase
				end
			end
			phts_pkg::S_STEP: begin
				cur_d = u_inc;
				if (!cur_max) begin
					offl_d = off_inc(offl_q);
					offf_d = off_inc(offf_q);
				end
				if (ph_q == phts_pkg::PH_EX ||
					(ph_q == phts_pkg::PH_MEM && cls_q == phts_pkg::CLS_STORE)) begin
					st_d = phts_pkg::S_RD1;
				end else begin
					st_d = phts_pkg::S_SKIP;
				end
			end
			// source register read: store checks rs2 before EXE, rs1 before MEM
			phts_pkg::S_RD1: begin
				ram_re    = 1'b1;
				ram_raddr = (ph_q == phts_pkg::PH_EX && cls_q == phts_pkg::CLS_STORE)
					? rs2_q : rs1_q;
				rvld_d    = vld_q[ram_raddr];
				st_d      = phts_pkg::S_RD2;
			end
			phts_pkg::S_RD2: begin
				rdy_d = rd_data;
				if (cls_q == phts_pkg::CLS_R && ph_q == phts_pkg::PH_EX) begin
					ram_re    = 1'b1;
					ram_raddr = rs2_q;
					rvld_d    = vld_q[ram_raddr];
					st_d      = phts_pkg::S_RSEL;
				end else begin
					st_d = phts_pkg::S_WCMP;
				end
			end
			// R-type waits on the later of its two sources; a tie keeps rs1
			phts_pkg::S_RSEL: begin
				rdy_d = u_flg.ge ? rdy_q : rd_data;
				st_d  = phts_pkg::S_WCMP;
			end
			phts_pkg::S_WCMP: begin
				st_d = u_flg.ge ? phts_pkg::S_WJMP : phts_pkg::S_SKIP;
			end
			// jump to the cycle after the source's WB, marking the skipped cells
			phts_pkg::S_WJMP: begin
				if (!cur_max) begin
					for (int k = 0; k < MAX_SPAN; k++) begin
						if (SPW'(k) >= offf_q && SPW'(k) < u_off) begin
							own_d[k] = 1'b1;
						end
					end
					sum    = {1'b0, u_off} + {1'b0, dfl_q};
					cur_d  = u_inc;
					offf_d = u_off;
					offl_d = (sum > (SPW+1)'(MAX_SPAN)) ? SPAN_OFF : sum[SPW-1:0];
				end
				st_d = phts_pkg::S_SKIP;
			end
			phts_pkg::S_DONE: begin
				if (!out_valid_q || timing.ready) begin
					out_valid_d = 1'b1;
					o_cls_d     = cls_q;
					o_f_d       = low_word(f_q);
					o_d_d       = low_word(d_q);
					o_e_d       = low_word(e_q);
					o_m_d       = low_word(m_q);
					o_wb_d      = low_word(cur_q);
					o_ovf_d     = !fmax_q && (offf_q == SPAN_OFF);
					if (cls_q <= phts_pkg::CLS_LOAD) begin
						ram_we       = 1'b1;
						vld_d[rd_q]  = 1'b1;
					end
					lf_d = f_q;
					pm_d = own_q;
					st_d = phts_pkg::S_IDLE;
				end
			end
			default: st_d = phts_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= phts_pkg::S_IDLE;
			ph_q        <= phts_pkg::PH_ID;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
			lf_q        <= '0;
			pm_q        <= '0;
		end else begin
			st_q        <= st_d;
			ph_q        <= ph_d;
			out_valid_q <= out_valid_d;
			vld_q       <= vld_d;
			lf_q        <= lf_d;
			pm_q        <= pm_d;
		end
	end

	always_ff @(posedge clk) begin
		cls_q   <= cls_d;
		rd_q    <= rd_d;
		rs1_q   <= rs1_d;
		rs2_q   <= rs2_d;
		cur_q   <= cur_d;
		f_q     <= f_d;
		d_q     <= d_d;
		e_q     <= e_d;
		m_q     <= m_d;
		rdy_q   <= rdy_d;
		offl_q  <= offl_d;
		offf_q  <= offf_d;
		dfl_q   <= dfl_d;
		own_q   <= own_d;
		fmax_q  <= fmax_d;
		rvld_q  <= rvld_d;
		o_cls_q <= o_cls_d;
		o_f_q   <= o_f_d;
		o_d_q   <= o_d_d;
		o_e_q   <= o_e_d;
		o_m_q   <= o_m_d;
		o_wb_q  <= o_wb_d;
		o_ovf_q <= o_ovf_d;
	end

endmodule

### hdl/phts_chk.sv
// Port-level checker for the scoreboard, bound to the top level.
// Depends on phts_pkg and pipeline_hazard_timing_scoreboard.
module phts_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [phts_pkg::CLASS_BITS-1:0]  out_class,
	input logic [phts_pkg::OUT_BITS-1:0]    out_fetch,
	input logic [phts_pkg::OUT_BITS-1:0]    out_exe,
	input logic [phts_pkg::OUT_BITS-1:0]    out_mem,
	input logic [phts_pkg::OUT_BITS-1:0]    out_wb
);

	// a taken request makes the block busy in the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted back to back");

	// a new result only appears from the busy state
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a request in work");

	// branch and unknown rows carry no EXE or MEM
	a_no_exe_mem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_class == phts_pkg::CLS_BRANCH || out_class == phts_pkg::CLS_UNKNOWN)
		|-> out_exe == '0 && out_mem == '0)
		else $error("EXE/MEM set for a class without them");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_class) && $stable(out_fetch)
		&& $stable(out_wb))
		else $error("stalled result changed");

endmodule

bind pipeline_hazard_timing_scoreboard phts_chk u_phts_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (instr.valid),
	.in_ready  (instr.ready),
	.out_valid (timing.valid),
	.out_ready (timing.ready),
	.out_class (timing.instr_class),
	.out_fetch (timing.fetch_cycle),
	.out_exe   (timing.execute_cycle),
	.out_mem   (timing.memory_cycle),
	.out_wb    (timing.writeback_cycle)
);
